@@ rtl/ludl_pkg.sv @@
// shared types, command codes and fixed-point helpers for the lu solver
package ludl_pkg;

  localparam int DEF_MAX_N     = 16;
  localparam int DEF_FRAC_BITS = 16;

  localparam logic [1:0] CMD_LOAD_COEF = 2'd0;
  localparam logic [1:0] CMD_LOAD_RHS  = 2'd1;
  localparam logic [1:0] CMD_SOLVE     = 2'd2;

  typedef struct packed {
    logic [1:0]         command;
    logic [3:0]         row;
    logic [3:0]         column;
    logic signed [31:0] value;
  } ludl_in_t;

  typedef struct packed {
    logic [3:0]         index;
    logic signed [31:0] solution;
    logic               singular;
    logic               last;
  } ludl_out_t;

  // control that travels with each partial quotient along the divider chain
  typedef struct packed {
    logic valid;
    logic neg;
  } ludl_div_ctl_t;

  function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
    logic signed [31:0] r;
    if (v > 64'sd2147483647) begin
      r = 32'sh7fffffff;
    end else if (v < -64'sd2147483648) begin
      r = 32'sh80000000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

endpackage

@@ rtl/ludl_div_cell.sv @@
// one restoring-division cell: produces one quotient bit per cycle
module ludl_div_cell
  import ludl_pkg::*;
#(
  parameter int W = 48
) (
  input  logic          clk,
  input  logic          rst,
  input  ludl_div_ctl_t in_ctl,
  input  logic [31:0]   in_rem,
  input  logic [W-1:0]  in_dq,
  input  logic [31:0]   in_den,
  output ludl_div_ctl_t out_ctl,
  output logic [31:0]   out_rem,
  output logic [W-1:0]  out_dq,
  output logic [31:0]   out_den
);

  logic [32:0] rs;
  logic        ge;
  logic [32:0] diff;

  assign rs   = {in_rem, in_dq[W-1]};
  assign ge   = rs >= {1'b0, in_den};
  assign diff = rs - {1'b0, in_den};

  always_ff @(posedge clk) begin
    if (rst) begin
      out_ctl <= '0;
    end else begin
      out_ctl <= in_ctl;
    end
    out_rem <= ge ? diff[31:0] : rs[31:0];
    out_dq  <= {in_dq[W-2:0], ge};
    out_den <= in_den;
  end

endmodule

@@ rtl/ludl_divider.sv @@
// signed fixed-point divider built as a chain of restoring cells, saturating
module ludl_divider
  import ludl_pkg::*;
#(
  parameter int FRAC_BITS = DEF_FRAC_BITS
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic signed [31:0] num,
  input  logic signed [31:0] den,
  output logic               done,
  output logic signed [31:0] quot
);

  localparam int W = 32 + FRAC_BITS;

  ludl_div_ctl_t ctl [W+1];
  logic [31:0]   rem [W+1];
  logic [W-1:0]  dq  [W+1];
  logic [31:0]   dv  [W+1];

  logic [31:0] num_mag;
  logic [31:0] den_mag;

  assign num_mag = num[31] ? (~num + 32'd1) : num;
  assign den_mag = den[31] ? (~den + 32'd1) : den;

  assign ctl[0].valid = start;
  assign ctl[0].neg   = num[31] ^ den[31];
  assign rem[0]       = '0;
  assign dq[0]        = {num_mag, {FRAC_BITS{1'b0}}};
  assign dv[0]        = den_mag;

  for (genvar g = 0; g < W; g++) begin : g_cell
    ludl_div_cell #(.W(W)) u_cell (
      .clk     (clk),
      .rst     (rst),
      .in_ctl  (ctl[g]),
      .in_rem  (rem[g]),
      .in_dq   (dq[g]),
      .in_den  (dv[g]),
      .out_ctl (ctl[g+1]),
      .out_rem (rem[g+1]),
      .out_dq  (dq[g+1]),
      .out_den (dv[g+1])
    );
  end

  logic [W-1:0] q;
  logic [31:0]  q_lo;
  assign q    = dq[W];
  assign q_lo = q[31:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= ctl[W].valid;
    end
    if (!ctl[W].neg) begin
      quot <= (q > W'(32'h7fffffff)) ? 32'sh7fffffff : q_lo;
    end else begin
      quot <= (q > W'(32'h80000000)) ? 32'sh80000000 : (~q_lo + 32'd1);
    end
  end

endmodule

@@ rtl/lu_doolittle_linear_solver.sv @@
// top level: load port, doolittle factoring and substitution sequencer, result port
//
// Solves A x = b in signed fixed point. Load transactions (coefficient or
// right-hand side) are taken one per cycle while the sequencer is idle. A solve
// transaction factors the matrix in place into unit-lower L and upper U without
// pivoting, then runs forward and backward substitution and returns one result
// transaction per unknown, index 0 first, last set on index n-1. While a solve
// runs, and until its last result is taken, no input transaction is taken. Each
// element of the factoring or substitution runs its product terms one after
// another through the one shared multiply-accumulate and the single matrix
// memory; every element that divides also waits for the divider cell chain.
// Results are offered one at a time, each only once the one before is taken. A
// zero pivot sets singular on every result and forces every solution to zero.
// system_size of 0 acts as 1 and values above MAX_N act as MAX_N; the
// configuration port is always ready.
module lu_doolittle_linear_solver
  import ludl_pkg::*;
#(
  parameter int MAX_N     = DEF_MAX_N,
  parameter int FRAC_BITS = DEF_FRAC_BITS
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_ready,
  input  ludl_in_t  in_data,
  output logic      out_valid,
  input  logic      out_ready,
  output ludl_out_t out_data,
  input  logic      cfg_valid,
  output logic      cfg_ready,
  input  logic [4:0] cfg_data
);

  localparam int IW    = (MAX_N > 1) ? $clog2(MAX_N) : 1;
  localparam int NW    = $clog2(MAX_N + 1);
  localparam int DEPTH = MAX_N * MAX_N;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int ACW   = 33 + $clog2(MAX_N);
  localparam int SZW   = (NW > 5) ? NW : 5;

  // sequencer states
  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_START = 4'd1;
  localparam logic [3:0] S_MRD   = 4'd2;
  localparam logic [3:0] S_MMUL  = 4'd3;
  localparam logic [3:0] S_MACC  = 4'd4;
  localparam logic [3:0] S_DRD   = 4'd5;
  localparam logic [3:0] S_DIF   = 4'd6;
  localparam logic [3:0] S_DIVW  = 4'd7;
  localparam logic [3:0] S_WR    = 4'd8;
  localparam logic [3:0] S_ORD   = 4'd9;
  localparam logic [3:0] S_OLD   = 4'd10;
  localparam logic [3:0] S_OSEND = 4'd11;

  // solve phases
  localparam logic [1:0] PH_FAC = 2'd0;
  localparam logic [1:0] PH_FWD = 2'd1;
  localparam logic [1:0] PH_BWD = 2'd2;

  function automatic logic [AW-1:0] maddr(input logic [IW-1:0] r, input logic [IW-1:0] c);
    return AW'(r) * AW'(MAX_N) + AW'(c);
  endfunction

  logic [3:0]    state;
  logic [1:0]    phase;
  logic [4:0]    size_reg;
  logic [NW-1:0] i;
  logic [NW-1:0] j;
  logic [NW-1:0] k;
  logic          zero;

  logic signed [ACW-1:0] acc;
  logic signed [63:0]    prod;
  logic signed [31:0]    dval;

  // configuration register; the host is bound to write it only while idle, which the block itself does not enforce
  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) begin
      size_reg <= 5'd1;
    end else if (cfg_valid && cfg_ready) begin
      size_reg <= cfg_data;
    end
  end

  // effective system size, clamped into 1..MAX_N
  logic [SZW-1:0] sz_ext;
  logic [NW-1:0]  n;
  assign sz_ext = SZW'(size_reg);
  assign n = (size_reg == 5'd0) ? NW'(1) :
             ((sz_ext > SZW'(MAX_N)) ? NW'(MAX_N) : NW'(size_reg));

  // memories: matrix with two read ports, right-hand side, y/x work vector
  logic signed [31:0] mat [DEPTH];
  logic signed [31:0] vec [MAX_N];
  logic signed [31:0] wk  [MAX_N];

  logic [AW-1:0]      ma_addr, mb_addr, mw_addr;
  logic               mw_en;
  logic signed [31:0] mw_data;
  logic signed [31:0] ma_q, mb_q, vec_q, wk_q;
  logic [IW-1:0]      wk_raddr;
  logic               wk_we;
  logic               vec_we;

  logic in_fire;
  logic row_ok, col_ok;
  assign in_ready = (state == S_IDLE);
  assign in_fire  = in_valid && in_ready;
  assign row_ok   = int'(in_data.row) < MAX_N;
  assign col_ok   = int'(in_data.column) < MAX_N;

  logic [IW-1:0] ii, jj, kk;
  assign ii = i[IW-1:0];
  assign jj = j[IW-1:0];
  assign kk = k[IW-1:0];

  always_comb begin
    ma_addr = (state == S_DRD) ? maddr(ii, jj) : maddr(ii, kk);
    if (state == S_DRD) begin
      mb_addr = (phase == PH_FAC) ? maddr(jj, jj) : maddr(ii, ii);
    end else begin
      mb_addr = maddr(kk, jj);
    end
    wk_raddr = (state == S_MRD) ? kk : ii;
    if (state == S_IDLE) begin
      mw_en   = in_fire && (in_data.command == CMD_LOAD_COEF) && row_ok && col_ok;
      mw_addr = maddr(IW'(in_data.row), IW'(in_data.column));
      mw_data = in_data.value;
    end else begin
      mw_en   = (state == S_WR) && (phase == PH_FAC);
      mw_addr = maddr(ii, jj);
      mw_data = dval;
    end
    vec_we = in_fire && (in_data.command == CMD_LOAD_RHS) && row_ok;
    wk_we  = (state == S_WR) && (phase != PH_FAC);
  end

  always_ff @(posedge clk) begin
    if (mw_en) begin
      mat[mw_addr] <= mw_data;
    end
    ma_q <= mat[ma_addr];
    mb_q <= mat[mb_addr];
  end

  always_ff @(posedge clk) begin
    if (vec_we) begin
      vec[IW'(in_data.row)] <= in_data.value;
    end
    vec_q <= vec[ii];
  end

  always_ff @(posedge clk) begin
    if (wk_we) begin
      wk[ii] <= dval;
    end
    wk_q <= wk[wk_raddr];
  end

  // product term loop bounds for the element at (i, j)
  logic [NW-1:0] k_start, k_end, k_inc;
  always_comb begin
    case (phase)
      PH_FAC: begin
        k_start = '0;
        k_end   = (i > j) ? j : i;
      end
      PH_FWD: begin
        k_start = '0;
        k_end   = i;
      end
      default: begin
        k_start = i + NW'(1);
        k_end   = n;
      end
    endcase
  end
  assign k_inc = k + NW'(1);

  // multiply-accumulate datapath: floor-shifted, saturated products summed exactly
  logic signed [31:0] opb;
  logic signed [63:0] prod_sh;
  logic signed [31:0] prod_sat;
  assign opb      = (phase == PH_FAC) ? mb_q : wk_q;
  assign prod_sh  = prod >>> FRAC_BITS;
  assign prod_sat = sat32(prod_sh);

  // element value: minuend less the sum, then optional division by the pivot
  logic signed [31:0] minu;
  logic signed [63:0] diff;
  logic signed [31:0] dsat;
  logic               need_div;
  always_comb begin
    case (phase)
      PH_FAC:  minu = ma_q;
      PH_FWD:  minu = vec_q;
      default: minu = wk_q;
    endcase
  end
  assign diff     = 64'(minu) - 64'(acc);
  assign dsat     = sat32(diff);
  assign need_div = (phase == PH_BWD) || ((phase == PH_FAC) && (i > j));

  logic               div_start;
  logic               div_done;
  logic signed [31:0] div_quot;
  assign div_start = (state == S_DIF) && need_div && (mb_q != 32'sd0);

  ludl_divider #(.FRAC_BITS(FRAC_BITS)) u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (dsat),
    .den   (mb_q),
    .done  (div_done),
    .quot  (div_quot)
  );

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      phase     <= PH_FAC;
      i         <= '0;
      j         <= '0;
      k         <= '0;
      zero      <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      case (state)
        S_IDLE: begin
          if (in_fire && (in_data.command == CMD_SOLVE)) begin
            phase <= PH_FAC;
            i     <= '0;
            j     <= '0;
            zero  <= 1'b0;
            state <= S_START;
          end
        end
        S_START: begin
          k     <= k_start;
          state <= (k_start == k_end) ? S_DRD : S_MRD;
        end
        S_MRD: begin
          state <= S_MMUL;
        end
        S_MMUL: begin
          state <= S_MACC;
        end
        S_MACC: begin
          k     <= k_inc;
          state <= (k_inc == k_end) ? S_DRD : S_MRD;
        end
        S_DRD: begin
          state <= S_DIF;
        end
        S_DIF: begin
          if (need_div && (mb_q == 32'sd0)) begin
            // division by a zero pivot gives zero and marks the system singular
            zero  <= 1'b1;
            state <= S_WR;
          end else if (need_div) begin
            state <= S_DIVW;
          end else begin
            state <= S_WR;
          end
        end
        S_DIVW: begin
          if (div_done) begin
            state <= S_WR;
          end
        end
        S_WR: begin
          case (phase)
            PH_FAC: begin
              state <= S_START;
              if (j + NW'(1) == n) begin
                j <= '0;
                if (i + NW'(1) == n) begin
                  i     <= '0;
                  phase <= PH_FWD;
                end else begin
                  i <= i + NW'(1);
                end
              end else begin
                j <= j + NW'(1);
              end
            end
            PH_FWD: begin
              state <= S_START;
              if (i + NW'(1) == n) begin
                i     <= n - NW'(1);
                phase <= PH_BWD;
              end else begin
                i <= i + NW'(1);
              end
            end
            default: begin
              if (i == '0) begin
                state <= S_ORD;
              end else begin
                i     <= i - NW'(1);
                state <= S_START;
              end
            end
          endcase
        end
        S_ORD: begin
          state <= S_OLD;
        end
        S_OLD: begin
          out_valid <= 1'b1;
          state     <= S_OSEND;
        end
        S_OSEND: begin
          if (out_ready) begin
            out_valid <= 1'b0;
            if (i == n - NW'(1)) begin
              state <= S_IDLE;
            end else begin
              i     <= i + NW'(1);
              state <= S_ORD;
            end
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (state == S_START) begin
      acc <= '0;
    end else if (state == S_MACC) begin
      acc <= acc + ACW'(prod_sat);
    end
    if (state == S_MMUL) begin
      prod <= ma_q * opb;
    end
    if (state == S_DIF) begin
      dval <= need_div ? 32'sd0 : dsat;
    end else if ((state == S_DIVW) && div_done) begin
      dval <= div_quot;
    end
    if (state == S_OLD) begin
      out_data.index    <= 4'(i);
      out_data.solution <= zero ? 32'sd0 : wk_q;
      out_data.singular <= zero;
      out_data.last     <= (i == n - NW'(1));
    end
  end

`ifndef SYNTH
  // no new transaction is taken while a result is on offer
  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    !(in_ready && out_valid))
    else $error("input taken while a result is pending");

  // a singular solve reports zero for every unknown
  a_singular_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_data.singular) |-> (out_data.solution == 32'sd0))
    else $error("nonzero solution on a singular result");

  // last marks the final unknown of the run
  a_last_index: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_data.last) |-> (out_data.index == 4'(n - NW'(1))))
    else $error("last flag on the wrong index");

  // a started division is always waited for
  a_div_wait: assert property (@(posedge clk) disable iff (rst)
    div_start |=> (state == S_DIVW))
    else $error("divider started without waiting");
`endif

endmodule

@@ tb/tb_lu_doolittle_linear_solver.sv @@
// testbench for lu_doolittle_linear_solver: directed and random solves checked against a predictor
`timescale 1ns / 100ps

module tb_lu_doolittle_linear_solver;
  import ludl_pkg::*;

  localparam int         N_MAX         = 16;
  localparam int         FRAC          = 16;
  localparam logic [1:0] CMD_NOP       = 2'd3;
  localparam int         STALL_LIMIT   = 100000;
  localparam int         HOLD_CYCLES   = 3000;
  localparam int         SETTLE_CYCLES = 20;
  localparam int         RANDOM_ITEMS  = 160;

  logic       clk;
  logic       rst;
  logic       in_valid;
  logic       in_ready;
  ludl_in_t   in_data;
  logic       out_valid;
  logic       out_ready;
  ludl_out_t  out_data;
  logic       cfg_valid;
  logic       cfg_ready;
  logic [4:0] cfg_data;

  lu_doolittle_linear_solver dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  // 8 ns clock
  always begin
    clk = 1'b1;
    #4;
    clk = 1'b0;
    #4;
  end

  // predictor state: its own copy of both stores and the size register
  logic signed [31:0] coef_mem [N_MAX][N_MAX];
  logic signed [31:0] rhs_mem  [N_MAX];
  bit                 coef_set [N_MAX][N_MAX];
  bit                 rhs_set  [N_MAX];
  logic [4:0]         size_reg;

  ludl_out_t solution_q[$];
  int        errors;
  int        items_sent;
  int        send_idle_pct;
  int        recv_stall_pct;
  int        pressure_req;
  int        pressure_seen;
  int        hold_left;
  int        quiet_cycles;

  // ---------------------------------------------------------------------------
  // fixed-point arithmetic, as the block is specified
  // ---------------------------------------------------------------------------
  function automatic logic signed [31:0] fx_sat(input longint v);
    if (v > 64'sd2147483647) return 32'sh7fffffff;
    if (v < -64'sd2147483648) return 32'sh80000000;
    return v[31:0];
  endfunction

  // arithmetic shift of the full product floors toward minus infinity
  function automatic longint fx_product(input logic signed [31:0] a,
                                        input logic signed [31:0] b);
    longint p;
    p = longint'(a) * longint'(b);
    return longint'(fx_sat(p >>> FRAC));
  endfunction

  // quotient truncates toward zero; a zero divisor gives 0 and marks singular
  function automatic logic signed [31:0] fx_quotient(input logic signed [31:0] num,
                                                     input logic signed [31:0] den,
                                                     inout bit zero);
    longint q;
    if (den == 0) begin
      zero = 1'b1;
      return 32'sd0;
    end
    q = (longint'(num) <<< FRAC) / longint'(den);
    return fx_sat(q);
  endfunction

  function automatic int active_size();
    if (size_reg == 0) return 1;
    if (size_reg > N_MAX) return N_MAX;
    return int'(size_reg);
  endfunction

  // in-place doolittle factoring, then forward and backward substitution
  task automatic predict_solution();
    int n, lim;
    bit zero;
    longint s;
    logic signed [31:0] d;
    logic signed [31:0] y [N_MAX];
    logic signed [31:0] x [N_MAX];
    ludl_out_t r;
    n = active_size();
    zero = 1'b0;
    for (int i = 0; i < n; i++) begin
      for (int j = 0; j < n; j++) begin
        lim = (i > j) ? j : i;
        s = 0;
        for (int k = 0; k < lim; k++) s += fx_product(coef_mem[i][k], coef_mem[k][j]);
        d = fx_sat(longint'(coef_mem[i][j]) - s);
        if (i > j) d = fx_quotient(d, coef_mem[j][j], zero);
        coef_mem[i][j] = d;
      end
    end
    for (int i = 0; i < n; i++) if (coef_mem[i][i] == 0) zero = 1'b1;
    for (int i = 0; i < n; i++) begin
      s = 0;
      for (int j = 0; j < i; j++) s += fx_product(coef_mem[i][j], y[j]);
      y[i] = fx_sat(longint'(rhs_mem[i]) - s);
    end
    for (int i = n - 1; i >= 0; i--) begin
      s = 0;
      for (int j = i + 1; j < n; j++) s += fx_product(coef_mem[i][j], x[j]);
      x[i] = fx_quotient(fx_sat(longint'(y[i]) - s), coef_mem[i][i], zero);
    end
    for (int i = 0; i < n; i++) begin
      r.index    = 4'(i);
      r.solution = zero ? 32'sd0 : x[i];
      r.singular = zero;
      r.last     = (i == n - 1);
      solution_q.push_back(r);
    end
  endtask

  // update the predictor for one accepted input transaction
  task automatic apply_item(input ludl_in_t it);
    case (it.command)
      CMD_LOAD_COEF: begin
        coef_mem[it.row][it.column] = it.value;
        coef_set[it.row][it.column] = 1'b1;
      end
      CMD_LOAD_RHS: begin
        rhs_mem[it.row] = it.value;
        rhs_set[it.row] = 1'b1;
      end
      CMD_SOLVE: predict_solution();
      default: ;
    endcase
  endtask

  // ---------------------------------------------------------------------------
  // input side
  // ---------------------------------------------------------------------------
  // valid is left high after acceptance; the next call lowers it only if it idles
  task automatic send_item(input ludl_in_t it);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= it;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    apply_item(it);
    items_sent++;
  endtask

  task automatic send_load(input logic [1:0] cmd, input int r, input int c,
                           input logic signed [31:0] v);
    ludl_in_t it;
    it.command = cmd;
    it.row     = 4'(r);
    it.column  = 4'(c);
    it.value   = v;
    send_item(it);
  endtask

  // fills any entry the solve would read but that was never written, then solves
  task automatic send_solve();
    ludl_in_t it;
    int n;
    n = active_size();
    for (int i = 0; i < n; i++) begin
      if (!rhs_set[i]) send_load(CMD_LOAD_RHS, i, $urandom_range(15), 32'($urandom));
      for (int j = 0; j < n; j++)
        if (!coef_set[i][j])
          send_load(CMD_LOAD_COEF, i, j, (i == j) ? 32'sh10000 : 32'sd0);
    end
    it.command = CMD_SOLVE;
    it.row     = 4'($urandom_range(15));
    it.column  = 4'($urandom_range(15));
    it.value   = 32'($urandom);
    send_item(it);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (solution_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // size register is only written with the block idle
  task automatic write_size(input logic [4:0] v);
    wait_drained();
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    size_reg = v;
    cfg_valid <= 1'b0;
  endtask

  // well-conditioned system: dominant diagonal, small off-diagonal terms
  task automatic load_system(input int n);
    logic signed [31:0] v;
    for (int i = 0; i < n; i++) begin
      for (int j = 0; j < n; j++) begin
        v = 32'($signed($urandom_range(262143)) - 131072);
        if (i == j) v = 32'(n * 262144) + 32'($urandom_range(131071));
        send_load(CMD_LOAD_COEF, i, j, v);
      end
      send_load(CMD_LOAD_RHS, i, $urandom_range(15),
                32'($signed($urandom_range(1048575)) - 524288));
    end
  endtask

  // ---------------------------------------------------------------------------
  // output side: receiver stalls and the result check
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
      hold_left = 0;
    end else begin
      if (pressure_req != pressure_seen) begin
        pressure_seen = pressure_req;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  always @(posedge clk) begin
    ludl_out_t exp_r;
    if (!rst && out_valid && out_ready) begin
      if (solution_q.size() == 0) begin
        $display("%0t: unexpected result, actual index=%0d solution=%h singular=%b last=%b",
                 $time, out_data.index, out_data.solution, out_data.singular,
                 out_data.last);
        errors++;
      end else begin
        exp_r = solution_q.pop_front();
        if (out_data.index !== exp_r.index) begin
          $display("%0t: index mismatch, expected %0d actual %0d",
                   $time, exp_r.index, out_data.index);
          errors++;
        end
        if (out_data.solution !== exp_r.solution) begin
          $display("%0t: solution mismatch at index %0d, expected %h actual %h",
                   $time, exp_r.index, exp_r.solution, out_data.solution);
          errors++;
        end
        if (out_data.singular !== exp_r.singular) begin
          $display("%0t: singular mismatch at index %0d, expected %b actual %b",
                   $time, exp_r.index, exp_r.singular, out_data.singular);
          errors++;
        end
        if (out_data.last !== exp_r.last) begin
          $display("%0t: last mismatch at index %0d, expected %b actual %b",
                   $time, exp_r.index, exp_r.last, out_data.last);
          errors++;
        end
      end
    end
  end

  // watchdog: cycles in a row in which no transaction moves on any port
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)
        || (cfg_valid && cfg_ready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("%0t: timeout, %0d results still expected", $time, solution_q.size());
        $display("tb_lu_doolittle_linear_solver NOT OK");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------------
  // 1x1 system at the reset size: 3.0 / 2.0
  task automatic test_single_unknown();
    send_load(CMD_LOAD_COEF, 0, 0, 32'sh20000);
    send_load(CMD_LOAD_RHS, 0, 0, 32'sh30000);
    send_solve();
  endtask

  // extreme values: saturating quotients and full-range fields
  task automatic test_extremes();
    send_load(CMD_LOAD_COEF, 0, 0, 32'sh7fffffff);
    send_load(CMD_LOAD_RHS, 0, 15, 32'sh80000000);
    send_solve();
    send_load(CMD_LOAD_COEF, 0, 0, 32'sh00000001);
    send_load(CMD_LOAD_RHS, 0, 0, 32'sh7fffffff);
    send_solve();
    send_load(CMD_LOAD_COEF, 0, 0, 32'sh80000000);
    send_solve();
    // loads beyond the active size are kept but not used
    send_load(CMD_LOAD_COEF, 15, 15, 32'shffffffff);
    send_load(CMD_LOAD_RHS, 15, 0, 32'sh55555555);
  endtask

  // zero pivot: every result zero and flagged singular
  task automatic test_zero_pivot();
    send_load(CMD_LOAD_COEF, 0, 0, 32'sd0);
    send_solve();
    write_size(5'd2);
    send_load(CMD_LOAD_COEF, 0, 0, 32'sh10000);
    send_load(CMD_LOAD_COEF, 0, 1, 32'sh20000);
    send_load(CMD_LOAD_COEF, 1, 0, 32'sh10000);
    send_load(CMD_LOAD_COEF, 1, 1, 32'sh20000);
    send_load(CMD_LOAD_RHS, 1, 0, 32'sh10000);
    send_solve();
  endtask

  // unknown command gives nothing; a second solve refactors the stored factors
  task automatic test_nop_and_refactor();
    ludl_in_t it;
    it.command = CMD_NOP;
    it.row     = 4'hf;
    it.column  = 4'hf;
    it.value   = 32'shffffffff;
    send_item(it);
    load_system(2);
    send_solve();
    send_solve();
  endtask

  // size register extremes, including zero and values past the maximum
  task automatic test_sizes();
    write_size(5'd0);
    send_solve();
    write_size(5'd31);
    load_system(16);
    send_solve();
    write_size(5'd17);
    send_solve();
    write_size(5'd16);
    send_solve();
    write_size(5'd3);
  endtask

  // receiver holds off while a solve drains; further loads must wait at the input
  task automatic test_backpressure();
    write_size(5'd4);
    load_system(4);
    send_solve();
    pressure_req++;
    load_system(4);
    send_solve();
  endtask

  // random traffic: mostly whole systems with random content, some noise
  task automatic test_random(input int send_pct, input int recv_pct, input int count);
    int stop_at, n, pick;
    ludl_in_t it;
    send_idle_pct  = send_pct;
    recv_stall_pct = recv_pct;
    stop_at = items_sent + count;
    while (items_sent < stop_at) begin
      pick = $urandom_range(99);
      if (pick < 8) begin
        // mostly small sizes; the largest now and then
        n = ($urandom_range(9) == 0) ? $urandom_range(16, 31) : $urandom_range(0, 5);
        write_size(5'(n));
      end else if (pick < 70) begin
        load_system(active_size());
        send_solve();
      end else if (pick < 80) begin
        // partial reload on top of old factors
        repeat ($urandom_range(1, 4))
          send_load(CMD_LOAD_COEF, $urandom_range(active_size() - 1),
                    $urandom_range(active_size() - 1), 32'($urandom));
        send_solve();
      end else begin
        it.command = 2'($urandom_range(3));
        if (it.command == CMD_SOLVE) it.command = CMD_NOP;
        it.row    = 4'($urandom_range(15));
        it.column = 4'($urandom_range(15));
        it.value  = 32'($urandom);
        send_item(it);
      end
    end
  endtask

  initial begin
    rst            = 1'b1;
    in_valid       = 1'b0;
    in_data        = '0;
    cfg_valid      = 1'b0;
    cfg_data       = '0;
    errors         = 0;
    items_sent     = 0;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    pressure_req   = 0;
    pressure_seen  = 0;
    quiet_cycles   = 0;
    size_reg       = 5'd1;
    foreach (coef_set[i, j]) coef_set[i][j] = 1'b0;
    foreach (rhs_set[i]) rhs_set[i] = 1'b0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_single_unknown();
    test_extremes();
    test_zero_pivot();
    test_nop_and_refactor();
    test_sizes();
    test_backpressure();
    test_random(0, 0, RANDOM_ITEMS / 4);
    test_random(69, 0, RANDOM_ITEMS / 4);
    test_random(0, 69, RANDOM_ITEMS / 4);
    test_random(32, 32, RANDOM_ITEMS / 4);

    wait_drained();
    if (errors == 0) begin
      $display("tb_lu_doolittle_linear_solver OK");
    end else begin
      $display("tb_lu_doolittle_linear_solver NOT OK");
    end
    $finish;
  end

endmodule

@@ files.f @@
rtl/ludl_pkg.sv
rtl/ludl_div_cell.sv
rtl/ludl_divider.sv
rtl/lu_doolittle_linear_solver.sv
tb/tb_lu_doolittle_linear_solver.sv
